// ===== hw/rtl/pse_pkg.sv =====
// shared constants for the postfix stack evaluator
`default_nettype none

package pse_pkg;

    // data path widths
    localparam int DATA_W   = 32;
    localparam int CH_W     = 8;
    localparam int STATUS_W = 3;

    // default operand stack depth
    localparam int STACK_DEPTH_DEF = 64;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DIVZERO   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BADCHAR   = 3'd4;

    // ascii codes of the token characters
    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_MUL   = 8'h2A;
    localparam logic [CH_W-1:0] CH_DIV   = 8'h2F;

endpackage : pse_pkg

`default_nettype wire

// ===== hw/rtl/postfix_stack_evaluator.sv =====
// postfix stack evaluator: sequencer, operand stack memory and shared alu/divider
//
// Usage: the input channel (in_valid/in_ready) carries one ASCII character of
// a postfix expression per transaction in ch, with last set on the final one.
// Digit runs form decimal numbers, a space separates tokens, and + - * / pop
// two operands and push the result. On the final character one transaction on
// the output channel (out_valid/out_ready) carries the top of the stack in
// value and a status code; value is zero when the status is not ok.
// Pacing: in_ready drops for the whole of one character's work, so a new
// character is taken only once the last is done. The / operator runs the 32
// steps of the shared restoring divider; an operator that faults skips the
// stack reads, and a zero divisor skips the divider. A final character then
// passes S_END, S_END_RD and S_END_VAL to close the number, read the top of
// the stack from the stack memory and register the result.
// Stall: a finished result waits in the output register while the next
// expression is taken in; only a second result waits for out_ready.
// Reset: clears the sequencer, stack pointer, number accumulator and fault
// code; the stack memory is not cleared and no clearing pass is needed.
`default_nettype none

module postfix_stack_evaluator
    import pse_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [CH_W-1:0]     ch,
    input  wire logic                last,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic signed [DATA_W-1:0] value,
    output logic [STATUS_W-1:0]      status
);

    localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int DCNT_W = $clog2(DATA_W);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHAR,
        S_ACT,
        S_RD2,
        S_EXEC,
        S_DIV,
        S_DIV_FIN,
        S_PUSH,
        S_END,
        S_END_RD,
        S_END_VAL
    } state_t;

    state_t                 state_reg, state_next;
    logic [CH_W-1:0]        ch_reg, ch_next;
    logic                   last_reg, last_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [DATA_W-1:0]      accum_reg, accum_next;
    logic                   open_reg, open_next;
    logic [STATUS_W-1:0]    fault_reg, fault_next;
    logic [DATA_W-1:0]      first_reg, first_next;
    logic [DATA_W-1:0]      res_reg, res_next;
    logic [DATA_W-1:0]      rem_reg, rem_next;
    logic [DATA_W-1:0]      mb_reg, mb_next;
    logic                   neg_reg, neg_next;
    logic [DCNT_W-1:0]      dcnt_reg, dcnt_next;
    logic [DATA_W-1:0]      value_reg, value_next;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic                   out_valid_reg, out_valid_next;

    // stack memory
    logic [DATA_W-1:0]      stack_mem [STACK_DEPTH];
    logic [DATA_W-1:0]      rdata_reg;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [DATA_W-1:0]      wr_data;
    logic                   rd_en;
    logic [IDX_W-1:0]       rd_addr;

    // character decode
    logic                   is_digit;
    logic                   is_op;
    logic [3:0]             digit;

    // push helper
    logic                   push_req;
    logic [DATA_W-1:0]      push_val;
    logic [CNT_W-1:0]       push_base;

    // divider step
    logic [DATA_W:0]        rem_sh;
    logic [DATA_W:0]        diff;

    logic                   can_out;
    logic [DATA_W-1:0]      second;
    logic [CNT_W-1:0]       cnt_m1;
    logic [CNT_W-1:0]       cnt_m2;
    logic [CH_W-1:0]        ch_off;

    assign ch_off   = ch_reg - CH_ZERO;
    assign is_digit = (ch_reg >= CH_ZERO) && (ch_reg <= CH_NINE);
    assign is_op    = (ch_reg == CH_PLUS) || (ch_reg == CH_MINUS) ||
                      (ch_reg == CH_MUL)  || (ch_reg == CH_DIV);
    assign digit    = ch_off[3:0];
    assign cnt_m1   = count_reg - CNT_W'(1);
    assign cnt_m2   = count_reg - CNT_W'(2);
    assign second   = rdata_reg;
    assign can_out  = !out_valid_reg || out_ready;
    assign rem_sh   = {rem_reg, res_reg[DATA_W-1]};
    assign diff     = rem_sh - {1'b0, mb_reg};

    // sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        ch_next        = ch_reg;
        last_next      = last_reg;
        count_next     = count_reg;
        accum_next     = accum_reg;
        open_next      = open_reg;
        fault_next     = fault_reg;
        first_next     = first_reg;
        res_next       = res_reg;
        rem_next       = rem_reg;
        mb_next        = mb_reg;
        neg_next       = neg_reg;
        dcnt_next      = dcnt_reg;
        value_next     = value_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && !out_ready;
        rd_en          = 1'b0;
        rd_addr        = '0;
        push_req       = 1'b0;
        push_val       = accum_reg;
        push_base      = count_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ch_next    = ch;
                    last_next  = last;
                    state_next = S_CHAR;
                end
            end
            S_CHAR:
            begin
                if (is_digit)
                begin
                    accum_next = (accum_reg << 3) + (accum_reg << 1) + DATA_W'(digit);
                    open_next  = 1'b1;
                    state_next = last_reg ? S_END : S_IDLE;
                end
                else
                begin
                    // a non-digit ends the open number
                    if (open_reg)
                    begin
                        push_req   = 1'b1;
                        open_next  = 1'b0;
                        accum_next = '0;
                    end
                    state_next = S_ACT;
                end
            end
            S_ACT:
            begin
                state_next = last_reg ? S_END : S_IDLE;
                if (ch_reg == CH_SPACE)
                begin
                    // separator only
                end
                else if (is_op)
                begin
                    if (fault_reg == ST_OK)
                    begin
                        if (count_reg < CNT_W'(2))
                        begin
                            fault_next = ST_UNDERFLOW;
                            count_next = '0;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = cnt_m1[IDX_W-1:0];
                            state_next = S_RD2;
                        end
                    end
                end
                else
                begin
                    if (fault_reg == ST_OK)
                        fault_next = ST_BADCHAR;
                    count_next = '0;
                end
            end
            S_RD2:
            begin
                first_next = rdata_reg;
                rd_en      = 1'b1;
                rd_addr    = cnt_m2[IDX_W-1:0];
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_PUSH;
                case (ch_reg)
                    CH_PLUS:  res_next = second + first_reg;
                    CH_MINUS: res_next = second - first_reg;
                    CH_MUL:   res_next = second * first_reg;
                    default:
                    begin
                        if (first_reg == '0)
                        begin
                            fault_next = ST_DIVZERO;
                            count_next = '0;
                            state_next = last_reg ? S_END : S_IDLE;
                        end
                        else
                        begin
                            // load magnitudes into the divider
                            res_next   = second[DATA_W-1] ? (DATA_W'(0) - second) : second;
                            mb_next    = first_reg[DATA_W-1] ? (DATA_W'(0) - first_reg)
                                                             : first_reg;
                            neg_next   = second[DATA_W-1] ^ first_reg[DATA_W-1];
                            rem_next   = '0;
                            dcnt_next  = '0;
                            state_next = S_DIV;
                        end
                    end
                endcase
            end
            S_DIV:
            begin
                // one restoring division step per cycle
                if (!diff[DATA_W])
                begin
                    rem_next = diff[DATA_W-1:0];
                    res_next = {res_reg[DATA_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[DATA_W-1:0];
                    res_next = {res_reg[DATA_W-2:0], 1'b0};
                end
                dcnt_next = dcnt_reg + DCNT_W'(1);
                if (dcnt_reg == DCNT_W'(DATA_W - 1))
                    state_next = S_DIV_FIN;
            end
            S_DIV_FIN:
            begin
                if (neg_reg)
                    res_next = DATA_W'(0) - res_reg;
                state_next = S_PUSH;
            end
            S_PUSH:
            begin
                push_req   = 1'b1;
                push_val   = res_reg;
                push_base  = cnt_m2;
                state_next = last_reg ? S_END : S_IDLE;
            end
            S_END:
            begin
                if (open_reg)
                begin
                    push_req   = 1'b1;
                    open_next  = 1'b0;
                    accum_next = '0;
                end
                state_next = S_END_RD;
            end
            S_END_RD:
            begin
                rd_en      = (fault_reg == ST_OK) && (count_reg != '0);
                rd_addr    = cnt_m1[IDX_W-1:0];
                state_next = S_END_VAL;
            end
            S_END_VAL:
            begin
                // wait here only while an earlier result is still pending
                if (can_out)
                begin
                    out_valid_next = 1'b1;
                    if (fault_reg != ST_OK)
                    begin
                        status_next = fault_reg;
                        value_next  = '0;
                    end
                    else if (count_reg == '0)
                    begin
                        status_next = ST_UNDERFLOW;
                        value_next  = '0;
                    end
                    else
                    begin
                        status_next = ST_OK;
                        value_next  = rdata_reg;
                    end
                    count_next = '0;
                    accum_next = '0;
                    open_next  = 1'b0;
                    fault_next = ST_OK;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // shared push: skipped after a fault, overflow on a full stack
        wr_en   = 1'b0;
        wr_addr = push_base[IDX_W-1:0];
        wr_data = push_val;
        if (push_req && (fault_reg == ST_OK))
        begin
            if (push_base >= CNT_W'(STACK_DEPTH))
            begin
                fault_next = ST_OVERFLOW;
                count_next = '0;
            end
            else
            begin
                wr_en      = 1'b1;
                count_next = push_base + CNT_W'(1);
            end
        end
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ch_reg        <= '0;
            last_reg      <= 1'b0;
            count_reg     <= '0;
            accum_reg     <= '0;
            open_reg      <= 1'b0;
            fault_reg     <= ST_OK;
            first_reg     <= '0;
            res_reg       <= '0;
            rem_reg       <= '0;
            mb_reg        <= '0;
            neg_reg       <= 1'b0;
            dcnt_reg      <= '0;
            value_reg     <= '0;
            status_reg    <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ch_reg        <= ch_next;
            last_reg      <= last_next;
            count_reg     <= count_next;
            accum_reg     <= accum_next;
            open_reg      <= open_next;
            fault_reg     <= fault_next;
            first_reg     <= first_next;
            res_reg       <= res_next;
            rem_reg       <= rem_next;
            mb_reg        <= mb_next;
            neg_reg       <= neg_next;
            dcnt_reg      <= dcnt_next;
            value_reg     <= value_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // operand stack: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            stack_mem[wr_addr] <= wr_data;
        if (rd_en)
            rdata_reg <= stack_mem[rd_addr];
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign status    = status_reg;

    // stack pointer never passes the stack depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack pointer beyond stack depth");

    // a fault always leaves the stack empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (fault_reg != ST_OK) |-> (count_reg == '0))
        else $error("stack not emptied after fault");

    // a result with a nonzero status carries a zero value
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg != ST_OK)) |-> (value_reg == '0))
        else $error("nonzero value with fault status");

    // the input is closed in the cycle after an accepted character
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input reopened right after a transaction");

    // the divider only runs on a nonzero divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (mb_reg != '0))
        else $error("divider running on zero divisor");

endmodule : postfix_stack_evaluator

`default_nettype wire

// ===== dv/tb_postfix_stack_evaluator.sv =====
// testbench for the postfix stack evaluator: directed and random expressions
module tb_postfix_stack_evaluator;
    timeunit 1ns;
    timeprecision 1ps;

    import pse_pkg::*;

    localparam int DEPTH         = STACK_DEPTH_DEF;
    localparam int RANDOM_ITEMS  = 1950;
    localparam int HOLD_CYCLES   = 400;
    localparam int QUIET_LIMIT   = 5000;
    localparam int DRAIN_CYCLES  = 60;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [STATUS_W-1:0]      status;
    } result_t;

    logic                     clk;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_ready;
    logic [CH_W-1:0]          ch        = '0;
    logic                     last      = 1'b0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [DATA_W-1:0] value;
    logic [STATUS_W-1:0]      status;

    // expected results, oldest first
    result_t pending_results[$];
    int      mismatches = 0;

    // evaluator state as predicted
    logic [DATA_W-1:0]   opnd_stack[DEPTH];
    int                  opnd_count = 0;
    logic [DATA_W-1:0]   num_accum  = '0;
    logic                num_open   = 1'b0;
    logic [STATUS_W-1:0] fault      = ST_OK;
    int                  live_items = 0;

    // sender idling and receiver hold-off control
    int                  burst_left = 0;
    bit                  hold_req   = 1'b0;
    logic [CH_W-1:0]     expr_chars[$];

    postfix_stack_evaluator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .ch        (ch),
        .last      (last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .value     (value),
        .status    (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // signed division truncating toward zero, wrapping on the most negative value
    function automatic logic [DATA_W-1:0] div_toward_zero(logic [DATA_W-1:0] num,
                                                         logic [DATA_W-1:0] den);
        logic [DATA_W-1:0] mag_n;
        logic [DATA_W-1:0] mag_d;
        logic [DATA_W-1:0] quo;
        mag_n = num[DATA_W-1] ? -num : num;
        mag_d = den[DATA_W-1] ? -den : den;
        quo   = mag_n / mag_d;
        return (num[DATA_W-1] != den[DATA_W-1]) ? -quo : quo;
    endfunction

    // first fault wins, stack is emptied
    function automatic void raise_fault(logic [STATUS_W-1:0] code);
        if (fault == ST_OK)
            fault = code;
        opnd_count = 0;
    endfunction

    function automatic void push_operand(logic [DATA_W-1:0] v);
        if (fault != ST_OK)
            return;
        if (opnd_count >= DEPTH)
        begin
            raise_fault(ST_OVERFLOW);
            return;
        end
        opnd_stack[opnd_count] = v;
        opnd_count++;
    endfunction

    function automatic void flush_number();
        if (num_open)
        begin
            push_operand(num_accum);
            num_open  = 1'b0;
            num_accum = '0;
        end
    endfunction

    // pops two operands and pushes second op first
    function automatic void apply_operator(logic [CH_W-1:0] c);
        logic [DATA_W-1:0] top;
        logic [DATA_W-1:0] below;
        logic [DATA_W-1:0] res;
        if (fault != ST_OK)
            return;
        if (opnd_count < 2)
        begin
            raise_fault(ST_UNDERFLOW);
            return;
        end
        top   = opnd_stack[opnd_count - 1];
        below = opnd_stack[opnd_count - 2];
        case (c)
            CH_PLUS:  res = below + top;
            CH_MINUS: res = below - top;
            CH_MUL:   res = below * top;
            default:
            begin
                if (top == '0)
                begin
                    raise_fault(ST_DIVZERO);
                    return;
                end
                res = div_toward_zero(below, top);
            end
        endcase
        opnd_count -= 2;
        push_operand(res);
    endfunction

    // predicts the effect of one accepted character
    function automatic void predict_char(logic [CH_W-1:0] c, logic fin);
        result_t r;
        if (fault == ST_OK)
            live_items++;
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            num_accum = num_accum * 32'd10 + 32'(c - CH_ZERO);
            num_open  = 1'b1;
        end
        else
        begin
            flush_number();
            if (c == CH_PLUS || c == CH_MINUS || c == CH_MUL || c == CH_DIV)
                apply_operator(c);
            else if (c != CH_SPACE)
                raise_fault(ST_BADCHAR);
        end
        if (!fin)
            return;
        flush_number();
        r.status = fault;
        r.value  = '0;
        if (fault == ST_OK)
        begin
            if (opnd_count == 0)
                r.status = ST_UNDERFLOW;
            else
                r.value = opnd_stack[opnd_count - 1];
        end
        pending_results.push_back(r);
        opnd_count = 0;
        num_accum  = '0;
        num_open   = 1'b0;
        fault      = ST_OK;
    endfunction

    // offers one character and waits for its transaction
    task automatic send_char(logic [CH_W-1:0] c, logic fin);
        int gap;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                burst_left = 120;
                gap = 0;
            end
            else
            begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        ch       <= c;
        last     <= fin;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
        predict_char(c, fin);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], i == s.len() - 1);
    endtask

    task automatic send_expr();
        for (int i = 0; i < expr_chars.size(); i++)
            send_char(expr_chars[i], i == expr_chars.size() - 1);
    endtask

    function automatic logic [CH_W-1:0] pick_operator();
        case ($urandom_range(0, 3))
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_MUL;
            default: return CH_DIV;
        endcase
    endfunction

    // digit run, mostly short, now and then long enough to wrap
    function automatic void add_number();
        int n_digits;
        int r;
        if (expr_chars.size() > 0 && expr_chars[$] >= CH_ZERO && expr_chars[$] <= CH_NINE)
            expr_chars.push_back(CH_SPACE);
        r = $urandom_range(0, 9);
        n_digits = (r < 7) ? $urandom_range(1, 2) :
                   (r < 9) ? $urandom_range(3, 6) : $urandom_range(7, 12);
        for (int i = 0; i < n_digits; i++)
            expr_chars.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    endfunction

    // mostly well-formed expressions, some deep, broken or pure noise
    function automatic void build_expr();
        int  kind;
        int  n_nums;
        int  pushed;
        int  depth;
        bit  deep;
        expr_chars.delete();
        kind = $urandom_range(0, 99);
        if (kind >= 88)
        begin
            repeat ($urandom_range(1, 10))
            begin
                case ($urandom_range(0, 3))
                    0:       expr_chars.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                    1:       expr_chars.push_back(CH_SPACE);
                    2:       expr_chars.push_back(pick_operator());
                    default: expr_chars.push_back(8'($urandom_range(0, 255)));
                endcase
            end
            return;
        end
        deep   = (kind >= 86);
        n_nums = deep ? $urandom_range(DEPTH - 8, DEPTH + 6) : $urandom_range(1, 10);
        pushed = 0;
        depth  = 0;
        while (pushed < n_nums || depth > 1)
        begin
            if (depth >= 2 && (pushed == n_nums || (!deep && $urandom_range(0, 2) == 0)))
            begin
                expr_chars.push_back(pick_operator());
                depth--;
            end
            else
            begin
                add_number();
                pushed++;
                depth++;
            end
            if ($urandom_range(0, 3) == 0)
                expr_chars.push_back(CH_SPACE);
        end
        // broken: one operator too many, or a stray character inside
        if (kind >= 80 && kind < 83)
            expr_chars.push_back(pick_operator());
        else if (kind >= 83 && kind < 86)
            expr_chars.insert($urandom_range(0, expr_chars.size() - 1),
                              8'($urandom_range(0, 255)));
    endfunction

    // every operator, negative division, final digit
    task automatic test_operators();
        send_text("3 4+");
        send_text("7 5-3*");
        send_text("0 7-2/");
        send_text("5");
    endtask

    // accumulator wrap, product wrap, most negative divided by minus one
    task automatic test_number_extremes();
        send_text("99999999999");
        send_text("4294967295 4294967295*");
        send_text("2147483648 0 1-/");
    endtask

    // underflow, divide by zero and bad character faults, empty stack at the end, chars ignored after a fault
    task automatic test_faults();
        send_text("1+");
        send_text("5 0/ 3");
        send_text("12a 3 4+");
        send_char(8'h31, 1'b0);
        send_char(8'hFF, 1'b1);
        send_char(8'h00, 1'b1);
        send_text(" ");
    endtask

    // a full stack is fine, one more push overflows
    task automatic test_stack_limits();
        for (int extra = 0; extra < 2; extra++)
        begin
            expr_chars.delete();
            for (int i = 0; i < DEPTH + extra; i++)
            begin
                expr_chars.push_back(CH_ZERO + 8'(i % 10));
                expr_chars.push_back(CH_SPACE);
            end
            for (int i = 0; i < DEPTH + extra - 1; i++)
                expr_chars.push_back(CH_PLUS);
            send_expr();
        end
    endtask

    // receiver holds off while short expressions keep coming
    task automatic test_backpressure();
        hold_req = 1'b1;
        for (int i = 0; i < 12; i++)
            send_text("12 3*");
    endtask

    task automatic test_random_expressions();
        while (live_items < RANDOM_ITEMS)
        begin
            build_expr();
            send_expr();
        end
    endtask

    // result check and receiver stall pattern
    int rx_mode      = 0;
    int rx_mode_left = 0;
    int hold_left    = 0;

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transaction: value %0d status %0d", value, status);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (value !== want.value)
                begin
                    $error("value: expected %0d, got %0d", want.value, value);
                    mismatches++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    mismatches++;
                end
            end
        end
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            if (rx_mode_left == 0)
            begin
                rx_mode      = $urandom_range(0, 2);
                rx_mode_left = $urandom_range(20, 200);
            end
            rx_mode_left--;
            case (rx_mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= ($urandom_range(0, 1) == 1);
                default: out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // watchdog on cycles without any transaction
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if ((in_valid === 1'b1 && in_ready === 1'b1) ||
            (out_valid === 1'b1 && out_ready === 1'b1))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // test sequence
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_operators();
        test_number_extremes();
        test_faults();
        test_stack_limits();
        test_backpressure();
        test_random_expressions();
        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
